[rtl/core/fbd_pkg.sv]
// ============================================================================
// fbd_pkg: shared types and constants of the framebuffer blit deframer
// Result codes, header constants, register indexes and the work word that
// travels from the parser to the result sequencer.
// ============================================================================
package fbd_pkg;

    // Result codes as seen on result_kind.
    typedef enum logic [2:0] {
        KIND_PIXEL      = 3'd0,
        KIND_REFRESH    = 3'd1,
        KIND_ACK_DONE   = 3'd2,
        KIND_ACK_REJECT = 3'd3,
        KIND_QUIT       = 3'd4,
        KIND_LOST_SYNC  = 3'd5,
        KIND_UNKNOWN_OP = 3'd6
    } fbd_kind_t;

    typedef enum logic {
        PHASE_HEADER,
        PHASE_PAYLOAD
    } fbd_phase_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LINE_STRIDE  = 2'd2;
    localparam logic [1:0] REG_GRAY8_FORMAT = 2'd3;

    localparam int CFG_DATA_W = 18;

    // Header layout and codes.
    localparam logic [7:0] MAGIC_0 = 8'h52; // 'R'
    localparam logic [7:0] MAGIC_1 = 8'h4D; // 'M'
    localparam logic [7:0] MAGIC_2 = 8'h46; // 'F'
    localparam logic [7:0] MAGIC_3 = 8'h42; // 'B'
    localparam logic [7:0] OP_BLIT = 8'd1;
    localparam logic [7:0] OP_QUIT = 8'd2;
    localparam logic [7:0] OP_SWAP = 8'd3;
    localparam logic [3:0] HDR_LAST = 4'd15;

    localparam logic [15:0] MAX_ROW = 16'd8192;
    localparam logic [7:0]  ALPHA   = 8'hFF;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  mode;
        logic [7:0]  refresh;
    } fbd_rect_t;

    // One queue word: everything that one input byte asks of the back end.
    typedef struct packed {
        logic        has_pixel;
        logic [23:0] addr;
        logic [7:0]  grey;
        logic        four;
        logic        has_refresh;
        fbd_rect_t   rect;
        logic        has_end;
        fbd_kind_t   end_kind;
    } fbd_work_t;

endpackage

[rtl/core/fbd_front.sv]
// ============================================================================
// fbd_front: command stream parser
// Collects the header, checks magic, op and rectangle fit, walks the payload
// and turns each byte into at most one work word for the queue.
// ============================================================================
module fbd_front #(
    parameter int FB_ADDR_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic [7:0]        data_byte,
    input  logic [15:0]       panel_width,
    input  logic [15:0]       panel_height,
    input  logic [17:0]       line_stride,
    input  logic              gray8_format,
    output logic              push,
    output fbd_pkg::fbd_work_t push_word
);
    import fbd_pkg::*;

    localparam int WIDE = 34;

    fbd_phase_t                phase_reg, phase_next;
    logic [3:0]                hidx_reg, hidx_next;
    logic [15:0]               col_reg, col_next;
    logic [15:0]               col_left_reg, col_left_next;
    logic [15:0]               rows_left_reg, rows_left_next;
    logic [FB_ADDR_BITS-1:0]   row_base_reg, row_base_next;
    logic                      fits_reg, fits_next;
    logic                      stopped_reg, stopped_next;

    logic [7:0]                hdr_reg [16];
    logic                      hdr_we;

    logic [15:0]               hx, hy, hw, hh, live_h;
    logic [33:0]               y_prod;
    logic                      magic_ok, fits_now;
    logic [17:0]               offset;
    logic [WIDE-1:0]           addr_sum, rb_adv;
    fbd_rect_t                 rect_hdr, rect_live;

    assign hx     = {hdr_reg[9], hdr_reg[8]};
    assign hy     = {hdr_reg[11], hdr_reg[10]};
    assign hw     = {hdr_reg[13], hdr_reg[12]};
    assign hh     = {hdr_reg[15], hdr_reg[14]};
    // On the last header byte the top half of h is still on the input.
    assign live_h = {data_byte, hdr_reg[14]};

    assign magic_ok = (hdr_reg[0] == MAGIC_0) && (hdr_reg[1] == MAGIC_1) &&
                      (hdr_reg[2] == MAGIC_2) && (hdr_reg[3] == MAGIC_3);

    assign fits_now = (hw != 16'd0) && (live_h != 16'd0) && (hw <= MAX_ROW) &&
                      (({1'b0, hx} + {1'b0, hw}) <= {1'b0, panel_width}) &&
                      (({1'b0, hy} + {1'b0, live_h}) <= {1'b0, panel_height});

    assign y_prod   = 34'(hy) * 34'(line_stride);
    assign offset   = gray8_format ? {2'b00, col_reg} : {col_reg, 2'b00};
    assign addr_sum = WIDE'(row_base_reg) + WIDE'(offset);
    assign rb_adv   = WIDE'(row_base_reg) + WIDE'(line_stride);

    assign rect_hdr  = '{x: hx, y: hy, w: hw, h: hh,
                         mode: hdr_reg[5], refresh: hdr_reg[6]};
    assign rect_live = '{x: hx, y: hy, w: hw, h: live_h,
                         mode: hdr_reg[5], refresh: hdr_reg[6]};

    always_comb
    begin
        phase_next     = phase_reg;
        hidx_next      = hidx_reg;
        col_next       = col_reg;
        col_left_next  = col_left_reg;
        rows_left_next = rows_left_reg;
        row_base_next  = row_base_reg;
        fits_next      = fits_reg;
        stopped_next   = stopped_reg;
        hdr_we         = 1'b0;
        push           = 1'b0;
        push_word      = '0;
        push_word.end_kind = KIND_PIXEL;

        if (in_accept && !stopped_reg)
        begin
            unique case (phase_reg)
                PHASE_HEADER:
                begin
                    hdr_we    = 1'b1;
                    hidx_next = hidx_reg + 4'd1;
                    if (hidx_reg == HDR_LAST)
                    begin
                        if (!magic_ok)
                        begin
                            push               = 1'b1;
                            push_word.has_end  = 1'b1;
                            push_word.end_kind = KIND_LOST_SYNC;
                            stopped_next       = 1'b1;
                        end
                        else if (hdr_reg[4] == OP_QUIT)
                        begin
                            push               = 1'b1;
                            push_word.has_end  = 1'b1;
                            push_word.end_kind = KIND_QUIT;
                            stopped_next       = 1'b1;
                        end
                        else if (hdr_reg[4] != OP_BLIT && hdr_reg[4] != OP_SWAP)
                        begin
                            push               = 1'b1;
                            push_word.has_end  = 1'b1;
                            push_word.end_kind = KIND_UNKNOWN_OP;
                            stopped_next       = 1'b1;
                        end
                        else
                        begin
                            fits_next = fits_now;
                            if (hdr_reg[4] == OP_BLIT && hw != 16'd0 && live_h != 16'd0)
                            begin
                                phase_next     = PHASE_PAYLOAD;
                                col_next       = hx;
                                col_left_next  = hw;
                                rows_left_next = live_h;
                                row_base_next  = y_prod[FB_ADDR_BITS-1:0];
                            end
                            else
                            begin
                                push                  = 1'b1;
                                push_word.has_refresh = fits_now;
                                push_word.rect        = fits_now ? rect_live : '0;
                                push_word.has_end     = 1'b1;
                                push_word.end_kind    = fits_now ? KIND_ACK_DONE
                                                                 : KIND_ACK_REJECT;
                            end
                        end
                    end
                end
                PHASE_PAYLOAD:
                begin
                    if (fits_reg)
                    begin
                        push                = 1'b1;
                        push_word.has_pixel = 1'b1;
                        push_word.addr      = 24'(addr_sum[FB_ADDR_BITS-1:0]);
                        push_word.grey      = data_byte;
                        push_word.four      = !gray8_format;
                    end
                    if (col_left_reg == 16'd1)
                    begin
                        col_next       = hx;
                        col_left_next  = hw;
                        rows_left_next = rows_left_reg - 16'd1;
                        row_base_next  = rb_adv[FB_ADDR_BITS-1:0];
                        if (rows_left_reg == 16'd1)
                        begin
                            phase_next            = PHASE_HEADER;
                            push                  = 1'b1;
                            push_word.has_refresh = fits_reg;
                            push_word.rect        = fits_reg ? rect_hdr : '0;
                            push_word.has_end     = 1'b1;
                            push_word.end_kind    = fits_reg ? KIND_ACK_DONE
                                                             : KIND_ACK_REJECT;
                        end
                    end
                    else
                    begin
                        col_next      = col_reg + 16'd1;
                        col_left_next = col_left_reg - 16'd1;
                    end
                end
                default:
                begin
                    phase_next = PHASE_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_HEADER;
            hidx_reg      <= 4'd0;
            col_reg       <= 16'd0;
            col_left_reg  <= 16'd0;
            rows_left_reg <= 16'd0;
            row_base_reg  <= '0;
            fits_reg      <= 1'b0;
            stopped_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hidx_reg      <= hidx_next;
            col_reg       <= col_next;
            col_left_reg  <= col_left_next;
            rows_left_reg <= rows_left_next;
            row_base_reg  <= row_base_next;
            fits_reg      <= fits_next;
            stopped_reg   <= stopped_next;
        end
    end

    // Header bytes hold no reset: each is written before this header reads it.
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[hidx_reg] <= data_byte;
        end
    end

endmodule

[rtl/core/fbd_queue.sv]
// ============================================================================
// fbd_queue: work word queue
// A short first-in first-out store between the parser and the result
// sequencer, so that each side can stall on its own.
// ============================================================================
module fbd_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fbd_pkg::fbd_work_t push_word,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output fbd_pkg::fbd_work_t head_word
);
    import fbd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fbd_work_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[rtl/core/fbd_back.sv]
// ============================================================================
// fbd_back: result sequencer
// Expands the head work word into its pixel write, refresh request and
// acknowledge or stopping result, one result word per cycle while out_stall is low, through the output register.
// ============================================================================
module fbd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  fbd_pkg::fbd_work_t head_word,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         result_kind,
    output logic [23:0]        pixel_address,
    output logic [31:0]        pixel_data,
    output logic               four_byte_write,
    output logic [15:0]        rect_x,
    output logic [15:0]        rect_y,
    output logic [15:0]        rect_w,
    output logic [15:0]        rect_h,
    output logic [7:0]         wave_mode,
    output logic [7:0]         refresh_kind,
    output logic               last_result
);
    import fbd_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        pix_done_reg, pix_done_next;
    logic        ref_done_reg, ref_done_next;
    logic [2:0]  kind_reg;
    logic [23:0] addr_reg;
    logic [31:0] data_reg;
    logic        four_reg;
    fbd_rect_t   rect_reg;
    logic        last_reg;

    logic        load, sel_pixel, sel_refresh, is_last;
    fbd_kind_t   sel_kind;

    assign load = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        sel_pixel   = 1'b0;
        sel_refresh = 1'b0;
        priority if (head_word.has_pixel && !pix_done_reg)
        begin
            sel_pixel = 1'b1;
            sel_kind  = KIND_PIXEL;
            is_last   = !head_word.has_refresh && !head_word.has_end;
        end
        else if (head_word.has_refresh && !ref_done_reg)
        begin
            sel_refresh = 1'b1;
            sel_kind    = KIND_REFRESH;
            is_last     = !head_word.has_end;
        end
        else
        begin
            sel_kind = head_word.end_kind;
            is_last  = 1'b1;
        end
    end

    assign pop = load && is_last;

    always_comb
    begin
        pix_done_next  = pix_done_reg;
        ref_done_next  = ref_done_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                pix_done_next = 1'b0;
                ref_done_next = 1'b0;
            end
            else
            begin
                pix_done_next = pix_done_reg || sel_pixel;
                ref_done_next = ref_done_reg || sel_refresh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pix_done_reg  <= 1'b0;
            ref_done_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pix_done_reg  <= pix_done_next;
            ref_done_reg  <= ref_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= sel_kind;
            addr_reg <= sel_pixel ? head_word.addr : 24'd0;
            if (!sel_pixel)
            begin
                data_reg <= 32'd0;
            end
            else if (head_word.four)
            begin
                data_reg <= {ALPHA, head_word.grey, head_word.grey, head_word.grey};
            end
            else
            begin
                data_reg <= {24'd0, head_word.grey};
            end
            four_reg <= sel_pixel && head_word.four;
            rect_reg <= sel_refresh ? head_word.rect : '0;
            last_reg <= is_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign pixel_address   = addr_reg;
    assign pixel_data      = data_reg;
    assign four_byte_write = four_reg;
    assign rect_x          = rect_reg.x;
    assign rect_y          = rect_reg.y;
    assign rect_w          = rect_reg.w;
    assign rect_h          = rect_reg.h;
    assign wave_mode       = rect_reg.mode;
    assign refresh_kind    = rect_reg.refresh;
    assign last_result     = last_reg;

endmodule

[rtl/core/framebuffer_blit_deframer.sv]
// ============================================================================
// framebuffer_blit_deframer: framebuffer blit command deframer
// Parses headers and grey payload bytes into framebuffer writes, refresh
// requests, acknowledges and stopping results.
// ============================================================================
// The block takes one stream byte per clock while in_stall is low. Header
// bytes and the bytes of a rejected payload produce nothing; each payload
// byte of a fitting blit becomes one pixel write, so a blit streams at one
// byte per cycle while the queue has room. The byte that ends a command
// yields up to three result words (last pixel, refresh, acknowledge), and
// the result sequencer behind the two-word queue sends one result word per
// cycle while out_stall is low; the parser keeps taking bytes until the
// queue is full. After a quit, a bad magic or an unknown op every byte is
// taken and ignored until reset.
module framebuffer_blit_deframer #(
    parameter int FB_ADDR_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [23:0] pixel_address,
    output logic [31:0] pixel_data,
    output logic        four_byte_write,
    output logic [15:0] rect_x,
    output logic [15:0] rect_y,
    output logic [15:0] rect_w,
    output logic [15:0] rect_h,
    output logic [7:0]  wave_mode,
    output logic [7:0]  refresh_kind,
    output logic        last_result
);
    import fbd_pkg::*;

    logic [15:0] panel_width_reg;
    logic [15:0] panel_height_reg;
    logic [17:0] line_stride_reg;
    logic        gray8_format_reg;

    logic        in_accept;
    logic        push, pop, q_full, head_valid;
    fbd_work_t   push_word, head_word;

    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= 16'd1620;
            panel_height_reg <= 16'd2160;
            line_stride_reg  <= 18'd1620;
            gray8_format_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PANEL_WIDTH:  panel_width_reg  <= cfg_data[15:0];
                REG_PANEL_HEIGHT: panel_height_reg <= cfg_data[15:0];
                REG_LINE_STRIDE:  line_stride_reg  <= cfg_data;
                REG_GRAY8_FORMAT: gray8_format_reg <= cfg_data[0];
                default:          gray8_format_reg <= gray8_format_reg;
            endcase
        end
    end

    fbd_front #(
        .FB_ADDR_BITS (FB_ADDR_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .data_byte    (data_byte),
        .panel_width  (panel_width_reg),
        .panel_height (panel_height_reg),
        .line_stride  (line_stride_reg),
        .gray8_format (gray8_format_reg),
        .push         (push),
        .push_word    (push_word)
    );

    fbd_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    fbd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_word       (head_word),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .pixel_address   (pixel_address),
        .pixel_data      (pixel_data),
        .four_byte_write (four_byte_write),
        .rect_x          (rect_x),
        .rect_y          (rect_y),
        .rect_w          (rect_w),
        .rect_h          (rect_h),
        .wave_mode       (wave_mode),
        .refresh_kind    (refresh_kind),
        .last_result     (last_result)
    );

    // The parser must never hand over a word while the queue is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("work word pushed into a full queue");

    // A refresh request is always followed by its acknowledge.
    a_refresh_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_REFRESH) |-> !last_result)
        else $error("refresh request marked as the final word of a byte");

    // Stopping results end the work of their byte.
    a_stop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == KIND_QUIT || result_kind == KIND_LOST_SYNC ||
                       result_kind == KIND_UNKNOWN_OP)) |-> last_result)
        else $error("stopping result not marked as the final word");

    // Only pixel writes carry address and data.
    a_pixel_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != KIND_PIXEL) |->
            (pixel_address == 24'd0 && pixel_data == 32'd0 && !four_byte_write))
        else $error("non-pixel word carries pixel fields");

endmodule
